// ===== sv/xnsd_pkg.sv =====
// ----------------------------------------------------------------------------
// xnsd_pkg
// Shared types and constants of the namespace declaration scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package xnsd_pkg;

    localparam int MAX_PAIRS     = 16;
    localparam int POSITION_BITS = 16;
    localparam int PAIR_W        = $clog2(MAX_PAIRS);
    localparam int S_DATA_W      = 8;
    localparam int M_DATA_W      = 32;

    localparam logic [7:0] CH_X = 8'h78;
    localparam logic [7:0] CH_M = 8'h6d;
    localparam logic [7:0] CH_L = 8'h6c;
    localparam logic [7:0] CH_N = 8'h6e;
    localparam logic [7:0] CH_S = 8'h73;

    typedef enum logic [10:0] {
        ST_WKEY = 11'b000_0000_0001,
        ST_WPFX = 11'b000_0000_0010,
        ST_RPFX = 11'b000_0000_0100,
        ST_WEQ  = 11'b000_0000_1000,
        ST_WURI = 11'b000_0001_0000,
        ST_RURI = 11'b000_0010_0000,
        ST_ERR  = 11'b000_0100_0000,
        ST_KM   = 11'b000_1000_0000,
        ST_KL   = 11'b001_0000_0000,
        ST_KN   = 11'b010_0000_0000,
        ST_KS   = 11'b100_0000_0000
    } state_t;

    typedef enum logic [2:0] {
        CL_BLANK,
        CL_EQ,
        CL_COLON,
        CL_QUOTE,
        CL_WORD,
        CL_OTHER
    } class_t;

    typedef struct packed {
        logic prefix_next;
        logic uri_next;
        logic term;
        logic pair_done;
    } event_t;

    typedef struct packed {
        state_t next_state;
        logic   count_up;
        event_t ev;
        logic   error;
    } step_t;

    // Result word, lowest field in the lowest bits.
    typedef struct packed {
        logic [5:0]  pad;
        logic        string_ok;
        logic        error;
        logic        pair_done;
        logic        terminator_here;
        logic        uri_begins_next;
        logic        prefix_begins_next;
        logic [3:0]  pair_index;
        logic [15:0] position;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/xnsd_class.sv =====
// ----------------------------------------------------------------------------
// xnsd_class
// Sorts one character into blank, equals, colon, quote, alphanumeric or other.
// ----------------------------------------------------------------------------
`default_nettype none

module xnsd_class (
    input  wire logic [7:0]      byte_value,
    output xnsd_pkg::class_t     byte_class
);
    import xnsd_pkg::*;

    always_comb begin
        if (byte_value == 8'd9 || byte_value == 8'd10 || byte_value == 8'd12 ||
            byte_value == 8'd13 || byte_value == 8'd32) begin
            byte_class = CL_BLANK;
        end else if (byte_value == 8'h3d) begin
            byte_class = CL_EQ;
        end else if (byte_value == 8'h3a) begin
            byte_class = CL_COLON;
        end else if (byte_value == 8'h22) begin
            byte_class = CL_QUOTE;
        end else if ((byte_value >= 8'h30 && byte_value <= 8'h39) ||
                     (byte_value >= 8'h41 && byte_value <= 8'h5a) ||
                     (byte_value >= 8'h61 && byte_value <= 8'h7a)) begin
            byte_class = CL_WORD;
        end else begin
            byte_class = CL_OTHER;
        end
    end

endmodule

`default_nettype wire

// ===== sv/xnsd_step.sv =====
// ----------------------------------------------------------------------------
// xnsd_step
// Transition table of the scanner: next state and events for one character.
// ----------------------------------------------------------------------------
`default_nettype none

module xnsd_step (
    input  wire xnsd_pkg::state_t state,
    input  wire logic [7:0]       byte_value,
    input  wire xnsd_pkg::class_t byte_class,
    input  wire logic             last_byte,
    input  wire logic             pair_full,
    output xnsd_pkg::step_t       step
);
    import xnsd_pkg::*;

    state_t ns;
    event_t ev;
    logic   count_up;

    always_comb begin
        ns       = ST_ERR;
        ev       = '0;
        count_up = 1'b0;
        unique case (state)
            ST_WKEY: begin
                if (byte_class == CL_BLANK) begin
                    ns = ST_WKEY;
                end else if (byte_class == CL_WORD && byte_value == CH_X) begin
                    ns = ST_KM;
                end
            end
            ST_WPFX: begin
                if (byte_class == CL_COLON) begin
                    ns             = ST_RPFX;
                    ev.prefix_next = 1'b1;
                end
            end
            ST_RPFX: begin
                if (byte_class == CL_BLANK) begin
                    ns      = ST_WEQ;
                    ev.term = 1'b1;
                end else if (byte_class == CL_EQ) begin
                    ns      = ST_WURI;
                    ev.term = 1'b1;
                end else if (byte_class == CL_WORD) begin
                    ns = ST_RPFX;
                end
            end
            ST_WEQ: begin
                if (byte_class == CL_BLANK) begin
                    ns = ST_WEQ;
                end else if (byte_class == CL_EQ) begin
                    ns = ST_WURI;
                end
            end
            ST_WURI: begin
                if (byte_class == CL_BLANK) begin
                    ns = ST_WURI;
                end else if (byte_class == CL_QUOTE) begin
                    ns          = ST_RURI;
                    ev.uri_next = 1'b1;
                end
            end
            ST_RURI: begin
                if (byte_class == CL_QUOTE) begin
                    ev.term      = 1'b1;
                    ev.pair_done = 1'b1;
                    // Reaching the pair limit is an error, not a count.
                    if (pair_full) begin
                        ns = ST_ERR;
                    end else begin
                        ns       = ST_WKEY;
                        count_up = 1'b1;
                    end
                end else begin
                    ns = ST_RURI;
                end
            end
            ST_ERR: ns = ST_ERR;
            ST_KM:  ns = (byte_value == CH_M) ? ST_KL : ST_ERR;
            ST_KL:  ns = (byte_value == CH_L) ? ST_KN : ST_ERR;
            ST_KN:  ns = (byte_value == CH_N) ? ST_KS : ST_ERR;
            ST_KS:  ns = (byte_value == CH_S) ? ST_WPFX : ST_ERR;
            default: ns = ST_ERR;
        endcase
    end

    always_comb begin
        step.next_state = ns;
        step.count_up   = count_up;
        step.ev         = ev;
        step.error      = (ns == ST_ERR) ||
                          (last_byte && (ns == ST_KM || ns == ST_KL ||
                                         ns == ST_KN || ns == ST_KS));
    end

endmodule

`default_nettype wire

// ===== sv/xml_namespace_decl_scanner.sv =====
// ----------------------------------------------------------------------------
// xml_namespace_decl_scanner
// Byte-wide scanner for strings of xmlns:prefix="uri" declarations.
// ----------------------------------------------------------------------------
// The block takes one character per word and returns one result word for it,
// and it accepts a new word in every cycle while the result side keeps up.
// Each word passes an input register and then a result register; it moves
// on only while the result side can take it. The work between them is a
// character class lookup and one step of the transition table. The word with
// tlast set closes the string and puts the scanner back to its reset state.
`default_nettype none

module xml_namespace_decl_scanner (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [xnsd_pkg::S_DATA_W-1:0] s_tdata,   // [7:0] byte_value
    input  wire logic                          s_tlast,   // last_byte
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [15:0] position, [19:16] pair_index, [20] prefix_begins_next,
    // [21] uri_begins_next, [22] terminator_here, [23] pair_done,
    // [24] error, [25] string_ok, [31:26] zero
    output logic [xnsd_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                               m_tlast    // string_done
);
    import xnsd_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_MAX  = '1;
    localparam logic [PAIR_W-1:0]        PAIR_TOP = PAIR_W'(MAX_PAIRS - 1);

    logic                     in_valid_reg;
    logic [7:0]               in_byte_reg;
    logic                     in_last_reg;
    logic                     out_valid_reg;
    result_t                  out_data_reg;
    logic                     out_last_reg;
    state_t                   state_reg;
    logic [POSITION_BITS-1:0] position_reg;
    logic [PAIR_W-1:0]        pair_count_reg;

    state_t                   state_next;
    logic [POSITION_BITS-1:0] position_next;
    logic [PAIR_W-1:0]        pair_count_next;
    result_t                  out_data_next;

    class_t      byte_class;
    step_t       step;
    logic        out_free;
    logic        advance;
    logic        s_fire;
    logic [31:0] pos_ext;
    logic [31:0] pair_ext;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    xnsd_class u_class (
        .byte_value (in_byte_reg),
        .byte_class (byte_class)
    );

    xnsd_step u_step (
        .state      (state_reg),
        .byte_value (in_byte_reg),
        .byte_class (byte_class),
        .last_byte  (in_last_reg),
        .pair_full  (pair_count_reg == PAIR_TOP),
        .step       (step)
    );

    assign pos_ext  = 32'(position_reg);
    assign pair_ext = 32'(pair_count_reg);

    always_comb begin
        out_data_next                    = '0;
        out_data_next.position           = pos_ext[15:0];
        out_data_next.pair_index         = pair_ext[3:0];
        out_data_next.prefix_begins_next = step.ev.prefix_next;
        out_data_next.uri_begins_next    = step.ev.uri_next;
        out_data_next.terminator_here    = step.ev.term;
        out_data_next.pair_done          = step.ev.pair_done;
        out_data_next.error              = step.error;
        out_data_next.string_ok          = in_last_reg && !step.error;

        if (in_last_reg) begin
            state_next      = ST_WKEY;
            position_next   = '0;
            pair_count_next = '0;
        end else begin
            state_next      = step.next_state;
            position_next   = (position_reg == POS_MAX) ? position_reg
                                                        : position_reg + 1'b1;
            pair_count_next = step.count_up ? pair_count_reg + 1'b1
                                            : pair_count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= ST_WKEY;
            position_reg   <= '0;
            pair_count_reg <= '0;
        end else begin
            if (s_fire) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg  <= 1'b1;
                state_reg      <= state_next;
                position_reg   <= position_next;
                pair_count_reg <= pair_count_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg <= s_tdata[7:0];
            in_last_reg <= s_tlast;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== sv/xnsd_checker.sv =====
// ----------------------------------------------------------------------------
// xnsd_checker
// Port-level checks of the namespace declaration scanner.
// ----------------------------------------------------------------------------
`default_nettype none

module xnsd_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [xnsd_pkg::S_DATA_W-1:0] s_tdata,
    input wire logic                          s_tlast,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [xnsd_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic                          m_tlast
);
    import xnsd_pkg::*;

    result_t res;
    assign res = m_tdata;

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result word changed");

    a_ok_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res.string_ok == (m_tlast && !res.error)))
        else $error("string_ok disagrees with tlast and error");

    a_pair_term: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.pair_done |-> res.terminator_here && !res.uri_begins_next)
        else $error("pair closed without a terminator");

    a_err_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.error && !res.pair_done |->
            !res.prefix_begins_next && !res.uri_begins_next && !res.terminator_here)
        else $error("events reported in the error state");

endmodule

bind xml_namespace_decl_scanner xnsd_checker u_xnsd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
